// File: src/in_order_ack_retire_tracker_unit_assert.svh
// Assertion macros for the in-order ack retire tracker.
// Needs clk and arst_n in the scope that uses them.
`ifndef IN_ORDER_ACK_RETIRE_TRACKER_UNIT_ASSERT_SVH
`define IN_ORDER_ACK_RETIRE_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IOART_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define IOART_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/ioart_pkg.sv
// Shared constants and types of the in-order ack retire tracker.
// No dependencies.
package ioart_pkg;

	localparam int WINDOW_DEPTH  = 64;
	localparam int BOOKMARK_BITS = 64;
	localparam int SLOT_W        = 6;
	localparam int COUNT_W       = 7;
	localparam int BM_PORT_W     = 64;

	// Window depth at the width used for modular slot arithmetic
	localparam logic [COUNT_W:0] DEPTH_X = (COUNT_W + 1)'(WINDOW_DEPTH);

	localparam logic OP_TRACK = 1'b0;
	localparam logic OP_ACK   = 1'b1;

	localparam logic [1:0] KIND_ABORTED   = 2'd1;
	localparam logic [1:0] KIND_SUSPENDED = 2'd2;

	localparam logic [1:0] FLOW_NONE    = 2'd0;
	localparam logic [1:0] FLOW_CREDIT  = 2'd1;
	localparam logic [1:0] FLOW_SUSPEND = 2'd2;

	typedef struct packed {
		logic              take;
		logic              op;
		logic [SLOT_W-1:0] slot;
		logic              step;
	} win_ctrl_t;

	typedef struct packed {
		logic               ok;
		logic [SLOT_W-1:0]  tail;
		logic [COUNT_W-1:0] count;
		logic [SLOT_W-1:0]  last;
	} win_stat_t;

endpackage

// File: src/ioart_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ioart_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/ioart_window.sv
// Ring window state: acked marks, head and occupancy, slot checks and the
// rotated search for the run of acked entries at the head. Uses ioart_pkg.
module ioart_window import ioart_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  win_ctrl_t ctrl,
	output win_stat_t stat
);

	logic [WINDOW_DEPTH-1:0]   marks_q;
	logic [WINDOW_DEPTH-1:0]   rot_s1;
	logic [SLOT_W-1:0]         head_q;
	logic [COUNT_W-1:0]        occ_q;
	logic                      ok_s1;
	logic                      op_s1;

	logic [COUNT_W:0]          head_x, occ_x, slot_x, tail_x, dist_x, cnt_x;
	logic [COUNT_W:0]          head_sum, last_sum;
	logic [SLOT_W-1:0]         tail, new_head, last;
	logic                      ack_ok, track_ok;
	logic [WINDOW_DEPTH-1:0]   set_vec, marks_set, occ_mask, rot_next;
	logic [WINDOW_DEPTH-1:0]   low_mask, clr_mask;
	logic [2*WINDOW_DEPTH-1:0] rot_dbl, clr_dbl;
	logic [COUNT_W-1:0]        cnt;

	// Checks and rotated marks at acceptance
	always_comb begin
		head_x   = (COUNT_W + 1)'(head_q);
		occ_x    = (COUNT_W + 1)'(occ_q);
		slot_x   = (COUNT_W + 1)'(ctrl.slot);
		tail_x   = head_x + occ_x;
		if (tail_x >= DEPTH_X) begin
			tail_x = tail_x - DEPTH_X;
		end
		tail     = tail_x[SLOT_W-1:0];
		dist_x   = (slot_x >= head_x) ? slot_x - head_x : slot_x + DEPTH_X - head_x;
		ack_ok   = (slot_x < DEPTH_X) && (dist_x < occ_x);
		track_ok = (occ_q != COUNT_W'(WINDOW_DEPTH));
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			set_vec[i]  = ack_ok && (slot_x == (COUNT_W + 1)'(i));
			occ_mask[i] = ((COUNT_W + 1)'(i) < occ_x);
		end
		marks_set = marks_q | set_vec;
		rot_dbl   = {marks_set, marks_set} >> head_q;
		rot_next  = rot_dbl[WINDOW_DEPTH-1:0] & occ_mask;
	end

	// Length of the acked run at the head, and where it ends
	always_comb begin
		cnt = COUNT_W'(WINDOW_DEPTH);
		for (int i = WINDOW_DEPTH - 1; i >= 0; i--) begin
			if (!rot_s1[i]) begin
				cnt = COUNT_W'(i);
			end
		end
		cnt_x = (COUNT_W + 1)'(cnt);
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			low_mask[i] = (COUNT_W'(i) < cnt);
		end
		clr_dbl  = {low_mask, low_mask} << head_q;
		clr_mask = clr_dbl[2*WINDOW_DEPTH-1:WINDOW_DEPTH];
		head_sum = head_x + cnt_x;
		if (head_sum >= DEPTH_X) begin
			head_sum = head_sum - DEPTH_X;
		end
		new_head = head_sum[SLOT_W-1:0];
		last_sum = (cnt == '0) ? head_x : head_x + cnt_x - (COUNT_W + 1)'(1);
		if (last_sum >= DEPTH_X) begin
			last_sum = last_sum - DEPTH_X;
		end
		last = last_sum[SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_q <= '0;
			head_q  <= '0;
			occ_q   <= '0;
			ok_s1   <= 1'b0;
			op_s1   <= OP_TRACK;
			rot_s1  <= '0;
		end else if (ctrl.take) begin
			op_s1 <= ctrl.op;
			if (ctrl.op == OP_ACK) begin
				ok_s1   <= ack_ok;
				marks_q <= marks_set;
				rot_s1  <= rot_next;
			end else begin
				ok_s1  <= track_ok;
				rot_s1 <= '0;
			end
		end else if (ctrl.step && ok_s1) begin
			if (op_s1 == OP_ACK) begin
				// drop the retired run and advance the head past it
				marks_q <= marks_q & ~clr_mask;
				head_q  <= new_head;
				occ_q   <= occ_q - cnt;
			end else begin
				marks_q[tail] <= 1'b0;
				occ_q         <= occ_q + COUNT_W'(1);
			end
		end
	end

	assign stat.ok    = ok_s1;
	assign stat.tail  = tail;
	assign stat.count = (op_s1 == OP_ACK) ? cnt : '0;
	assign stat.last  = last;

endmodule

// File: src/in_order_ack_retire_tracker_unit.sv
// In-order ack retire tracker. A track transaction takes the tail slot of a
// 64-entry ring and stores its bookmark; an ack transaction marks a slot acked,
// retires the run of acked entries from the head and returns the count, the
// bookmark of the last retired entry and a flow action. Every transaction gives
// exactly one result, after the CALC and LOAD states. In steady state the CALC
// state does the rotated run search and state update and LOAD the registered
// read of the bookmark memory, with the next acceptance overlapping the result
// load while the output register is free. The output register lets a finished
// result wait while the next transaction is taken. No clearing pass after reset.
// Uses ioart_pkg, ioart_window and ioart_ram.
module in_order_ack_retire_tracker_unit import ioart_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic [SLOT_W-1:0]    entry_slot,
	input  logic [BM_PORT_W-1:0] bookmark_data,
	input  logic [1:0]           ack_kind,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 accepted,
	output logic [SLOT_W-1:0]    assigned_slot,
	output logic [COUNT_W-1:0]   retired_count,
	output logic                 save_valid,
	output logic [BM_PORT_W-1:0] saved_bookmark,
	output logic [1:0]           flow_action
);

	`include "in_order_ack_retire_tracker_unit_assert.svh"

	typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_LOAD} state_t;

	state_t                   state_q;
	logic                     op_s1;
	logic [1:0]               kind_s1;
	logic [BOOKMARK_BITS-1:0] bm_s1;
	logic                     acc_s2, sv_s2;
	logic [SLOT_W-1:0]        slot_s2;
	logic [SLOT_W-1:0]        last_s2;
	logic [COUNT_W-1:0]       cnt_s2;
	logic [1:0]               flow_s2;
	logic                     out_valid_q, accepted_q, save_valid_q;
	logic [SLOT_W-1:0]        assigned_slot_q;
	logic [COUNT_W-1:0]       retired_count_q;
	logic [BM_PORT_W-1:0]     saved_bookmark_q;
	logic [1:0]               flow_action_q;

	logic                     out_free, take, ram_we, load_out;
	logic                     ack_hit;
	logic [SLOT_W-1:0]        ram_raddr;
	win_ctrl_t                win_ctrl;
	win_stat_t                win_stat;
	logic [BOOKMARK_BITS-1:0] ram_rdata;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_LOAD) && out_free);
	assign take     = in_valid && in_ready;
	assign load_out = (state_q == ST_LOAD) && out_free;

	assign win_ctrl.take = take;
	assign win_ctrl.op   = operation;
	assign win_ctrl.slot = entry_slot;
	assign win_ctrl.step = (state_q == ST_CALC);

	assign ram_we  = (state_q == ST_CALC) && (op_s1 == OP_TRACK) && win_stat.ok;
	assign ack_hit = (op_s1 == OP_ACK) && win_stat.ok && (win_stat.count != '0);

	// Hold the read address while the result waits, the head has moved on by then
	assign ram_raddr = (state_q == ST_LOAD) ? last_s2 : win_stat.last;

	ioart_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (win_ctrl),
		.stat   (win_stat)
	);

	ioart_ram #(
		.WIDTH (BOOKMARK_BITS),
		.DEPTH (WINDOW_DEPTH)
	) u_bookmark_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (win_stat.tail),
		.wdata (bm_s1),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Hold the transaction payload for the calculation cycle
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1   <= operation;
			kind_s1 <= ack_kind;
			bm_s1   <= bookmark_data[BOOKMARK_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			acc_s2           <= 1'b0;
			slot_s2          <= '0;
			last_s2          <= '0;
			cnt_s2           <= '0;
			sv_s2            <= 1'b0;
			flow_s2          <= FLOW_NONE;
			out_valid_q      <= 1'b0;
			accepted_q       <= 1'b0;
			assigned_slot_q  <= '0;
			retired_count_q  <= '0;
			save_valid_q     <= 1'b0;
			saved_bookmark_q <= '0;
			flow_action_q    <= FLOW_NONE;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					acc_s2  <= win_stat.ok;
					slot_s2 <= ((op_s1 == OP_TRACK) && win_stat.ok) ? win_stat.tail : '0;
					last_s2 <= win_stat.last;
					cnt_s2  <= ack_hit ? win_stat.count : '0;
					sv_s2   <= ack_hit && (kind_s1 != KIND_ABORTED);
					if (!ack_hit) begin
						flow_s2 <= FLOW_NONE;
					end else if (kind_s1 == KIND_SUSPENDED) begin
						flow_s2 <= FLOW_SUSPEND;
					end else begin
						flow_s2 <= FLOW_CREDIT;
					end
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						accepted_q       <= acc_s2;
						assigned_slot_q  <= slot_s2;
						retired_count_q  <= cnt_s2;
						save_valid_q     <= sv_s2;
						saved_bookmark_q <= sv_s2 ? BM_PORT_W'(ram_rdata) : '0;
						flow_action_q    <= flow_s2;
						state_q          <= take ? ST_CALC : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = accepted_q;
	assign assigned_slot  = assigned_slot_q;
	assign retired_count  = retired_count_q;
	assign save_valid     = save_valid_q;
	assign saved_bookmark = saved_bookmark_q;
	assign flow_action    = flow_action_q;

	`IOART_ASSERT_NEXT(a_calc_then_load, state_q == ST_CALC, state_q == ST_LOAD, "calc not followed by load")
	`IOART_ASSERT_NOW(a_refused_is_empty, out_valid_q && !accepted_q, (assigned_slot_q == '0) && (retired_count_q == '0) && (flow_action_q == FLOW_NONE), "refused result not empty")
	`IOART_ASSERT_NOW(a_save_needs_retire, out_valid_q && save_valid_q, (retired_count_q != '0) && (flow_action_q != FLOW_NONE), "bookmark save without retirement")

endmodule
